// File: rtl/spce_pkg.sv
package spce_pkg;

    // instruction codes
    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_INIT_CX = 3'd0;
    localparam logic [2:0] REG_INIT_CY = 3'd1;
    localparam logic [2:0] REG_INIT_CZ = 3'd2;
    localparam logic [2:0] REG_RADIUS  = 3'd3;
    localparam logic [2:0] REG_WEIGHT  = 3'd4;

    // request and status of the shared divide / square root unit
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } spce_ds_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } spce_ds_stat_t;

    // saturate a magnitude to a signed 32-bit result
    function automatic logic [31:0] sat_out(input logic [47:0] mag, input logic neg);
        logic [47:0] m;
        begin
            if (neg) begin
                m = (mag > 48'h0000_8000_0000) ? 48'h0000_8000_0000 : mag;
                return 32'(48'd0 - m);
            end
            m = (mag > 48'h0000_7fff_ffff) ? 48'h0000_7fff_ffff : mag;
            return m[31:0];
        end
    endfunction

    // saturating signed 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        begin
            s = {a[31], a} + {b[31], b};
            if (s[32] != s[31])
                return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
            return s[31:0];
        end
    endfunction

    // row and column of each unique hessian entry: xx xy xz yy yz zz
    function automatic logic [1:0] hess_row(input logic [2:0] k);
        begin
            case (k)
                3'd0, 3'd1, 3'd2: return 2'd0;
                3'd3, 3'd4:       return 2'd1;
                default:          return 2'd2;
            endcase
        end
    endfunction

    function automatic logic [1:0] hess_col(input logic [2:0] k);
        begin
            case (k)
                3'd0:       return 2'd0;
                3'd1, 3'd3: return 2'd1;
                default:    return 2'd2;
            endcase
        end
    endfunction

endpackage

// File: rtl/sphere_penalty_contact_eval_unit.sv
// from the input transfer to result valid, a move item or a far point goes straight to
//   the finish state, an outside point sums the squares and tests them against r squared,
//   an inside point then takes the root and value, and off the center the gradient and
//   hessian; one item at a time, the next item can be taken once result valid is set;
//   the shared divide / square root unit does one root, three gradient and three direction
//   divides; a finished result waits in the output register while the next item is taken
// reset: asynchronous active low; center 0, radius 1.0, weight 1.0, no result
module sphere_penalty_contact_eval_unit
    import spce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item channel
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        op,
    input  logic [31:0] px,
    input  logic [31:0] py,
    input  logic [31:0] pz,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic        is_inside,
    output logic        degenerate,
    output logic [30:0] value,
    output logic [31:0] grad_x,
    output logic [31:0] grad_y,
    output logic [31:0] grad_z,
    output logic [31:0] hess_xx,
    output logic [31:0] hess_xy,
    output logic [31:0] hess_xz,
    output logic [31:0] hess_yy,
    output logic [31:0] hess_yz,
    output logic [31:0] hess_zz
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SSUM,
        ST_RCMP,
        ST_SQRT,
        ST_PEN2,
        ST_VLO,
        ST_VHI,
        ST_GMUL,
        ST_GDIV,
        ST_GSC,
        ST_JDIV,
        ST_HMUL,
        ST_HSC,
        ST_FIN
    } state_t;

    state_t state_reg;

    // configuration and center state
    logic [31:0] init_cx_reg, init_cy_reg, init_cz_reg;
    logic [30:0] radius_reg, weight_reg;
    logic [31:0] cx_reg, cy_reg, cz_reg;

    // per item working registers
    logic [30:0] a_reg [3];
    logic        neg_reg [3];
    logic        pos_reg [3];
    logic [16:0] jn_reg [3];
    logic [2:0]  idx_reg;
    logic [63:0] s_reg;
    logic [31:0] n_reg;
    logic [30:0] pen_reg;
    logic [45:0] sq_reg;
    logic [63:0] plo_reg;
    logic [31:0] opa_reg, opb_reg;

    // staged result
    logic        ins_reg, deg_reg;
    logic [30:0] val_reg;
    logic [31:0] grad_reg [3];
    logic [31:0] hess_reg [6];

    // output register
    logic        result_valid_reg;
    logic        out_ins_reg, out_deg_reg;
    logic [30:0] out_val_reg;
    logic [31:0] out_grad_reg [3];
    logic [31:0] out_hess_reg [6];

    // shared multiplier
    logic [63:0] prod;
    assign prod = opa_reg * opb_reg;

    // shared divide / square root unit
    spce_ds_req_t  ds_req;
    spce_ds_stat_t ds_stat;
    logic [63:0]   ds_dividend;
    logic [31:0]   ds_result;

    logic [1:0] ai;
    logic [1:0] next_ai;
    logic [1:0] hr_next, hc_next, hr_cur, hc_cur;
    logic       inside_now;
    logic [77:0] vfull;
    logic [61:0] v62;

    assign ai         = idx_reg[1:0];
    assign next_ai    = ai + 2'd1;
    assign hr_cur     = hess_row(idx_reg);
    assign hc_cur     = hess_col(idx_reg);
    assign hr_next    = hess_row(idx_reg + 3'd1);
    assign hc_next    = hess_col(idx_reg + 3'd1);
    assign inside_now = (s_reg < prod);
    assign vfull      = {14'd0, plo_reg} + {prod[45:0], 32'd0};
    assign v62        = vfull[77:16];

    always_comb
    begin
        ds_req.start     = 1'b0;
        ds_req.sqrt_mode = 1'b0;
        ds_dividend      = prod;
        case (state_reg)
            ST_RCMP:
            begin
                ds_req.start     = inside_now;
                ds_req.sqrt_mode = 1'b1;
                ds_dividend      = s_reg;
            end
            ST_GMUL:
            begin
                ds_req.start = 1'b1;
            end
            ST_GSC:
            begin
                ds_req.start = 1'b1;
                ds_dividend  = {17'd0, a_reg[ai], 16'd0};
            end
            default:
            begin
                ds_req.start = 1'b0;
            end
        endcase
    end

    spce_divsqrt u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ds_req),
        .dividend (ds_dividend),
        .divisor  (n_reg),
        .stat     (ds_stat),
        .result   (ds_result)
    );

    // apb access
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[4:2])
            REG_INIT_CX: prdata = init_cx_reg;
            REG_INIT_CY: prdata = init_cy_reg;
            REG_INIT_CZ: prdata = init_cz_reg;
            REG_RADIUS:  prdata = {1'b0, radius_reg};
            REG_WEIGHT:  prdata = {1'b0, weight_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // difference to the center at accept time
    logic [32:0] d_acc [3];
    logic [32:0] a_acc [3];
    logic [31:0] p_in [3];
    logic [31:0] c_cur [3];
    logic        far_acc;

    assign p_in[0]  = px;
    assign p_in[1]  = py;
    assign p_in[2]  = pz;
    assign c_cur[0] = cx_reg;
    assign c_cur[1] = cy_reg;
    assign c_cur[2] = cz_reg;

    always_comb
    begin
        far_acc = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d_acc[i] = {p_in[i][31], p_in[i]} - {c_cur[i][31], c_cur[i]};
            a_acc[i] = d_acc[i][32] ? (33'd0 - d_acc[i]) : d_acc[i];
            far_acc  = far_acc | a_acc[i][32] | a_acc[i][31];
        end
    end

    assign item_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            init_cx_reg      <= '0;
            init_cy_reg      <= '0;
            init_cz_reg      <= '0;
            radius_reg       <= 31'd65536;
            weight_reg       <= 31'd65536;
            cx_reg           <= '0;
            cy_reg           <= '0;
            cz_reg           <= '0;
            idx_reg          <= '0;
        end
        else
        begin
            // register writes, also reloading the center
            if (cfg_wr)
            begin
                case (paddr[4:2])
                    REG_INIT_CX: begin init_cx_reg <= pwdata; cx_reg <= pwdata; end
                    REG_INIT_CY: begin init_cy_reg <= pwdata; cy_reg <= pwdata; end
                    REG_INIT_CZ: begin init_cz_reg <= pwdata; cz_reg <= pwdata; end
                    REG_RADIUS:  radius_reg <= pwdata[30:0];
                    REG_WEIGHT:  weight_reg <= pwdata[30:0];
                    default:     ;
                endcase
            end

            // result transfer, the finish state reloads the register itself
            if (result_valid_reg && result_ready && state_reg != ST_FIN)
                result_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        ins_reg <= 1'b0;
                        deg_reg <= 1'b0;
                        val_reg <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            grad_reg[i] <= '0;
                            a_reg[i]    <= a_acc[i][30:0];
                            neg_reg[i]  <= d_acc[i][32];
                            pos_reg[i]  <= ~d_acc[i][32] & (d_acc[i] != 33'd0);
                        end
                        for (int k = 0; k < 6; k++)
                            hess_reg[k] <= '0;
                        s_reg   <= '0;
                        idx_reg <= '0;
                        opa_reg <= {1'b0, a_acc[0][30:0]};
                        opb_reg <= {1'b0, a_acc[0][30:0]};
                        if (op == OP_MOVE)
                        begin
                            cx_reg    <= sat_add(cx_reg, px);
                            cy_reg    <= sat_add(cy_reg, py);
                            cz_reg    <= sat_add(cz_reg, pz);
                            state_reg <= ST_FIN;
                        end
                        else if (far_acc)
                            state_reg <= ST_FIN;
                        else
                            state_reg <= ST_SSUM;
                    end
                end

                // squared distance, one axis per cycle
                ST_SSUM:
                begin
                    s_reg <= s_reg + prod;
                    if (idx_reg == 3'd2)
                    begin
                        opa_reg   <= {1'b0, radius_reg};
                        opb_reg   <= {1'b0, radius_reg};
                        state_reg <= ST_RCMP;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        opa_reg   <= {1'b0, a_reg[next_ai]};
                        opb_reg   <= {1'b0, a_reg[next_ai]};
                    end
                end

                // strict inside test against r squared, root starts here
                ST_RCMP:
                begin
                    if (inside_now)
                    begin
                        ins_reg   <= 1'b1;
                        state_reg <= ST_SQRT;
                    end
                    else
                        state_reg <= ST_FIN;
                end

                ST_SQRT:
                begin
                    if (ds_stat.done)
                    begin
                        n_reg     <= ds_result;
                        pen_reg   <= radius_reg - ds_result[30:0];
                        opa_reg   <= {1'b0, radius_reg - ds_result[30:0]};
                        opb_reg   <= {1'b0, radius_reg - ds_result[30:0]};
                        state_reg <= ST_PEN2;
                    end
                end

                // value = ((pen^2 >> 16) * w) >> 16 in two partial products
                ST_PEN2:
                begin
                    sq_reg    <= prod[61:16];
                    opa_reg   <= {1'b0, weight_reg};
                    opb_reg   <= prod[47:16];
                    state_reg <= ST_VLO;
                end

                ST_VLO:
                begin
                    plo_reg   <= prod;
                    opb_reg   <= {18'd0, sq_reg[45:32]};
                    state_reg <= ST_VHI;
                end

                ST_VHI:
                begin
                    val_reg <= (v62[61:31] != 31'd0) ? 31'h7fff_ffff : v62[30:0];
                    if (s_reg == 64'd0)
                    begin
                        // point on the center: no direction
                        deg_reg   <= 1'b1;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        opa_reg   <= {1'b0, a_reg[0]};
                        opb_reg   <= {1'b0, pen_reg};
                        state_reg <= ST_GMUL;
                    end
                end

                // t = |d| * pen / n, divide starts here
                ST_GMUL:
                begin
                    state_reg <= ST_GDIV;
                end

                ST_GDIV:
                begin
                    if (ds_stat.done)
                    begin
                        opa_reg   <= {1'b0, weight_reg};
                        opb_reg   <= ds_result;
                        state_reg <= ST_GSC;
                    end
                end

                // gradient = 2 w t >> 16, direction divide starts here
                ST_GSC:
                begin
                    grad_reg[ai] <= sat_out(prod[62:15], pos_reg[ai]);
                    state_reg    <= ST_JDIV;
                end

                ST_JDIV:
                begin
                    if (ds_stat.done)
                    begin
                        jn_reg[ai] <= ds_result[16:0];
                        if (idx_reg == 3'd2)
                        begin
                            idx_reg   <= '0;
                            opa_reg   <= {15'd0, jn_reg[0]};
                            opb_reg   <= {15'd0, jn_reg[0]};
                            state_reg <= ST_HMUL;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            opa_reg   <= {1'b0, a_reg[next_ai]};
                            opb_reg   <= {1'b0, pen_reg};
                            state_reg <= ST_GMUL;
                        end
                    end
                end

                // hessian entry: (ji*jj >> 16), then 2 w h >> 16
                ST_HMUL:
                begin
                    opa_reg   <= {1'b0, weight_reg};
                    opb_reg   <= {15'd0, prod[32:16]};
                    state_reg <= ST_HSC;
                end

                ST_HSC:
                begin
                    hess_reg[idx_reg] <= sat_out(prod[62:15],
                                                 neg_reg[hr_cur] ^ neg_reg[hc_cur]);
                    if (idx_reg == 3'd5)
                        state_reg <= ST_FIN;
                    else
                    begin
                        idx_reg   <= idx_reg + 3'd1;
                        opa_reg   <= {15'd0, jn_reg[hr_next]};
                        opb_reg   <= {15'd0, jn_reg[hc_next]};
                        state_reg <= ST_HMUL;
                    end
                end

                // hand the staged result to the output register when it is free
                ST_FIN:
                begin
                    if (!result_valid_reg || result_ready)
                    begin
                        result_valid_reg <= 1'b1;
                        out_ins_reg      <= ins_reg;
                        out_deg_reg      <= deg_reg;
                        out_val_reg      <= val_reg;
                        out_grad_reg     <= grad_reg;
                        out_hess_reg     <= hess_reg;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign is_inside    = out_ins_reg;
    assign degenerate   = out_deg_reg;
    assign value        = out_val_reg;
    assign grad_x       = out_grad_reg[0];
    assign grad_y       = out_grad_reg[1];
    assign grad_z       = out_grad_reg[2];
    assign hess_xx      = out_hess_reg[0];
    assign hess_xy      = out_hess_reg[1];
    assign hess_xz      = out_hess_reg[2];
    assign hess_yy      = out_hess_reg[3];
    assign hess_yz      = out_hess_reg[4];
    assign hess_zz      = out_hess_reg[5];

    // the shared unit is never restarted while it is working
    assert property (@(posedge clk) disable iff (!rst_n)
        ds_req.start |-> !ds_stat.busy)
        else $error("divide/sqrt unit restarted while busy");

    // a degenerate result is always an inside result with no gradient
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |-> is_inside && grad_x == 32'd0 && hess_xx == 32'd0)
        else $error("degenerate result with nonzero fields");

    // an outside result carries all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_inside |-> value == 31'd0 && !degenerate && grad_y == 32'd0)
        else $error("outside result not zero");

endmodule

// File: rtl/spce_divsqrt.sv
module spce_divsqrt
    import spce_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  spce_ds_req_t  req,
    input  logic [63:0]   dividend,
    input  logic [31:0]   divisor,
    output spce_ds_stat_t stat,
    output logic [31:0]   result
);

    logic        busy_reg;
    logic        done_reg;
    logic        mode_reg;
    logic [4:0]  cnt_reg;
    logic [34:0] rem_reg;
    logic [63:0] sh_reg;
    logic [31:0] q_reg;
    logic [31:0] dvs_reg;

    logic [34:0] trial;
    logic [34:0] cmp;
    logic        ge;
    logic [34:0] diff;

    // one quotient or root bit per cycle through one compare and subtract
    always_comb
    begin
        if (mode_reg)
        begin
            trial = {rem_reg[32:0], sh_reg[63:62]};
            cmp   = {1'b0, q_reg, 2'b01};
        end
        else
        begin
            trial = {2'b00, rem_reg[31:0], sh_reg[63]};
            cmp   = {3'b000, dvs_reg};
        end
        ge   = (trial >= cmp);
        diff = trial - cmp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mode_reg <= req.sqrt_mode;
            dvs_reg  <= divisor;
            q_reg    <= '0;
            if (req.sqrt_mode)
            begin
                rem_reg <= '0;
                sh_reg  <= dividend;
            end
            else
            begin
                rem_reg <= {3'b000, dividend[63:32]};
                sh_reg  <= {dividend[31:0], 32'd0};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : trial;
            q_reg   <= {q_reg[30:0], ge};
            sh_reg  <= mode_reg ? {sh_reg[61:0], 2'b00} : {sh_reg[62:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = q_reg;

endmodule

// File: tb/sphere_penalty_contact_eval_unit_test.sv
module sphere_penalty_contact_eval_unit_test;
    import spce_pkg::*;

    // cycles with no transfer on any port before the run is declared hung;
    // the receiver holds off for HOLD_LEN
    localparam int STALL_LIMIT = 6000;
    localparam int HOLD_LEN    = 700;
    localparam int DRAIN_WAIT  = 300;
    localparam int NUM_PHASES  = 8;
    localparam int NUM_DIRECTED = 16;
    // one address past the register list, a write there must change nothing
    localparam logic [4:0] ADDR_SPARE = 5'd20;
    localparam longint unsigned MASK31 = 64'h7fff_ffff;
    localparam longint unsigned ALL_ONES = 64'hffff_ffff_ffff_ffff;

    // one result transfer, as the block presents it
    typedef struct packed {
        logic             is_inside;
        logic             degenerate;
        logic [30:0]      value;
        logic [2:0][31:0] grad;
        logic [5:0][31:0] hess;
    } contact_t;

    // one row of the directed table
    typedef struct packed {
        logic        op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        known;
        contact_t    res;
    } probe_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_ready;
    logic        op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        result_valid;
    logic        result_ready;
    logic        is_inside;
    logic        degenerate;
    logic [30:0] value;
    logic [31:0] grad_x;
    logic [31:0] grad_y;
    logic [31:0] grad_z;
    logic [31:0] hess_xx;
    logic [31:0] hess_xy;
    logic [31:0] hess_xz;
    logic [31:0] hess_yy;
    logic [31:0] hess_yz;
    logic [31:0] hess_zz;

    sphere_penalty_contact_eval_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .px           (px),
        .py           (py),
        .pz           (pz),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_inside    (is_inside),
        .degenerate   (degenerate),
        .value        (value),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .grad_z       (grad_z),
        .hess_xx      (hess_xx),
        .hess_xy      (hess_xy),
        .hess_xz      (hess_xz),
        .hess_yy      (hess_yy),
        .hess_yz      (hess_yz),
        .hess_zz      (hess_zz)
    );

    // 10 unit period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the block's registers and sphere center
    longint signed   sh_init[3];
    longint signed   sh_ctr[3];
    longint unsigned sh_radius;
    longint unsigned sh_weight;

    // results still owed by the block, oldest first
    contact_t pending_q[$];

    int tx_idle;
    int rx_idle;
    int mismatches;
    int hold_req;
    int hold_seen;
    int hold_left;
    int stall_cnt;

    // floor of the square root of a 64-bit integer
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // magnitude plus sign to a saturated 32-bit two's complement word
    function automatic logic [31:0] signed_sat(longint unsigned mag, logic neg);
        longint unsigned m;
        if (neg)
        begin
            m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
            return 32'(64'd0 - m);
        end
        m = (mag > MASK31) ? MASK31 : mag;
        return m[31:0];
    endfunction

    function automatic longint signed clamp_s32(longint signed v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // expected result of one item; a move also shifts the shadow center
    function automatic contact_t penalty_predict(logic op_i, logic [31:0] x,
                                                 logic [31:0] y, logic [31:0] z);
        contact_t        r;
        longint signed   p[3];
        longint signed   d[3];
        longint unsigned a[3];
        longint unsigned jn[3];
        longint unsigned s;
        longint unsigned n;
        longint unsigned pen;
        longint unsigned sq;
        longint unsigned val;
        longint unsigned t;
        longint unsigned h;
        int              k;
        r = '0;
        p[0] = longint'($signed(x));
        p[1] = longint'($signed(y));
        p[2] = longint'($signed(z));
        if (op_i == OP_MOVE)
        begin
            for (int i = 0; i < 3; i++)
                sh_ctr[i] = clamp_s32(sh_ctr[i] + p[i]);
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            d[i] = p[i] - sh_ctr[i];
            a[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
            // far point: treated as outside
            if (a[i] >= 64'h8000_0000)
                return r;
        end
        s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        if (!(s < sh_radius * sh_radius))
            return r;
        r.is_inside = 1'b1;
        n = root_floor(s);
        pen = sh_radius - n;
        sq = (pen * pen) >> 16;
        if (sq != 0 && sh_weight > ALL_ONES / sq)
            val = MASK31;
        else
            val = (sh_weight * sq) >> 16;
        r.value = (val > MASK31) ? 31'h7fff_ffff : val[30:0];
        // point on the center: no direction, gradient and hessian stay zero
        if (s == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            t = (a[i] * pen) / n;
            r.grad[i] = signed_sat((2 * sh_weight * t) >> 16, d[i] > 0);
            jn[i] = (a[i] << 16) / n;
        end
        k = 0;
        for (int i = 0; i < 3; i++)
            for (int j = i; j < 3; j++)
            begin
                h = (jn[i] * jn[j]) >> 16;
                r.hess[k] = signed_sat((2 * sh_weight * h) >> 16, (d[i] < 0) != (d[j] < 0));
                k++;
            end
        return r;
    endfunction

    // register write through the configuration port, setup then access
    task automatic reg_write(logic [4:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // the write lands at this edge (pready is always high)
        case (addr[4:2])
            REG_INIT_CX:
            begin
                sh_init[0] = longint'($signed(data));
                sh_ctr[0]  = sh_init[0];
            end
            REG_INIT_CY:
            begin
                sh_init[1] = longint'($signed(data));
                sh_ctr[1]  = sh_init[1];
            end
            REG_INIT_CZ:
            begin
                sh_init[2] = longint'($signed(data));
                sh_ctr[2]  = sh_init[2];
            end
            REG_RADIUS: sh_radius = longint'(data) & MASK31;
            REG_WEIGHT: sh_weight = longint'(data) & MASK31;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // offer one item, hold it until the transfer, then maybe go idle
    task automatic send_item(logic op_i, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic known, contact_t fixed);
        contact_t exp_res;
        item_valid <= 1'b1;
        op         <= op_i;
        px         <= x;
        py         <= y;
        pz         <= z;
        do
            @(posedge clk);
        while (!item_ready);
        exp_res = penalty_predict(op_i, x, y, z);
        // rows with a typed-in answer are checked against that answer
        pending_q.push_back(known ? fixed : exp_res);
        while ($urandom_range(99) < tx_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0)
            @(posedge clk);
        // then a margin before the caller goes on
        repeat (8) @(posedge clk);
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= rx_idle);
    end

    // result checker, compares every transfer with the oldest expectation
    always @(posedge clk)
    begin
        contact_t got;
        contact_t want;
        if (rst_n && result_valid && result_ready)
        begin
            got.is_inside  = is_inside;
            got.degenerate = degenerate;
            got.value      = value;
            got.grad       = {grad_z, grad_y, grad_x};
            got.hess       = {hess_zz, hess_yz, hess_yy, hess_xz, hess_xy, hess_xx};
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer at %0t", $time);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.is_inside !== want.is_inside || got.degenerate !== want.degenerate
                    || got.value !== want.value || got.grad !== want.grad
                    || got.hess !== want.hess)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t", $time);
                        $display("  inside exp %b got %b  degenerate exp %b got %b",
                                 want.is_inside, got.is_inside,
                                 want.degenerate, got.degenerate);
                        $display("  value exp %h got %h", want.value, got.value);
                        $display("  grad  exp %h got %h", want.grad, got.grad);
                        $display("  hess  exp %h got %h", want.hess, got.hess);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready)
                || (psel && penable))
                stall_cnt = 0;
            else
                stall_cnt = stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    probe_row_t probes[NUM_DIRECTED];

    // directed rows; known answers only where they are obvious
    task automatic fill_probes();
        contact_t zero;
        contact_t unit_deg;
        zero = '0;
        unit_deg = '0;
        unit_deg.is_inside  = 1'b1;
        unit_deg.degenerate = 1'b1;
        unit_deg.value      = 31'h0001_0000;
        // point on the center after reset: w*R^2 = 1.0
        probes[0]  = '{OP_EVAL, 32'h0, 32'h0, 32'h0, 1'b1, unit_deg};
        // two units away, outside
        probes[1]  = '{OP_EVAL, 32'h0002_0000, 32'h0, 32'h0, 1'b1, zero};
        // far point on each axis, then the largest positive point, which is outside
        probes[2]  = '{OP_EVAL, 32'h8000_0000, 32'h0, 32'h0, 1'b1, zero};
        probes[3]  = '{OP_EVAL, 32'h0, 32'h8000_0000, 32'h0, 1'b1, zero};
        probes[4]  = '{OP_EVAL, 32'h0, 32'h0, 32'h8000_0000, 1'b1, zero};
        probes[5]  = '{OP_EVAL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, zero};
        // inside, each axis and each sign
        probes[6]  = '{OP_EVAL, 32'h0000_8000, 32'h0, 32'h0, 1'b0, zero};
        probes[7]  = '{OP_EVAL, 32'h0, 32'hffff_8000, 32'h0, 1'b0, zero};
        probes[8]  = '{OP_EVAL, 32'h0000_4000, 32'hffff_c000, 32'h0000_4000, 1'b0, zero};
        probes[9]  = '{OP_EVAL, 32'hffff_f000, 32'h0000_0001, 32'hffff_ffff, 1'b0, zero};
        // moves, the second saturates the center on every axis
        probes[10] = '{OP_MOVE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, zero};
        probes[11] = '{OP_MOVE, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1'b1, zero};
        // on the saturated center, and just beside it
        probes[12] = '{OP_EVAL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, unit_deg};
        probes[13] = '{OP_EVAL, 32'h7fff_f000, 32'h8000_1000, 32'h7fff_8000, 1'b0, zero};
        // move back through the other extreme
        probes[14] = '{OP_MOVE, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, zero};
        probes[15] = '{OP_EVAL, 32'hffff_c000, 32'hffff_ffff, 32'hffff_ffff, 1'b0, zero};
    endtask

    // register set for each phase, the first three are the extremes
    task automatic load_phase_regs(int ph);
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] rad;
        logic [31:0] wgt;
        case (ph)
            0:
            begin
                cx = 32'h7fff_ffff; cy = 32'h8000_0000; cz = 32'h0;
                rad = 32'h7fff_ffff; wgt = 32'h7fff_ffff;
            end
            1:
            begin
                cx = 32'h0; cy = 32'h0; cz = 32'h0;
                rad = 32'h0; wgt = 32'h0;
            end
            2:
            begin
                cx = $urandom; cy = $urandom; cz = $urandom;
                rad = 32'h1; wgt = 32'h7fff_ffff;
            end
            default:
            begin
                cx = $urandom; cy = $urandom; cz = $urandom;
                rad = $urandom_range(32'h0000_0100, 32'h0400_0000);
                wgt = ($urandom_range(3) == 0) ? ($urandom & 32'h7fff_ffff)
                                               : $urandom_range(32'h0004_0000);
            end
        endcase
        reg_write({REG_INIT_CX, 2'b00}, cx);
        reg_write({REG_INIT_CY, 2'b00}, cy);
        reg_write({REG_INIT_CZ, 2'b00}, cz);
        reg_write({REG_RADIUS, 2'b00}, rad);
        reg_write({REG_WEIGHT, 2'b00}, wgt);
        reg_write(ADDR_SPARE, $urandom);
    endtask

    // one random item: mostly points around the sphere, some moves and noise
    task automatic random_item();
        int unsigned     roll;
        int unsigned     m;
        longint signed   off[3];
        logic [31:0]     v[3];
        contact_t        none;
        none = '0;
        roll = $urandom_range(99);
        m = int'(sh_radius[31:0]);
        if (roll < 10)
        begin
            // small center move
            m = (m >> 2) + 1;
            for (int i = 0; i < 3; i++)
                v[i] = 32'(longint'($urandom_range(2 * m)) - longint'(m));
            send_item(OP_MOVE, v[0], v[1], v[2], 1'b0, none);
        end
        else if (roll < 16)
            send_item(logic'($urandom_range(1)), $urandom, $urandom, $urandom, 1'b0, none);
        else if (roll < 19)
            send_item(OP_EVAL, 32'(sh_ctr[0]), 32'(sh_ctr[1]), 32'(sh_ctr[2]), 1'b0, none);
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                off[i] = longint'($urandom_range(2 * m)) - longint'(m);
                v[i] = 32'(sh_ctr[i] + off[i]);
            end
            send_item(OP_EVAL, v[0], v[1], v[2], 1'b0, none);
        end
    endtask

    initial
    begin
        int count;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        item_valid <= 1'b0;
        op         <= OP_EVAL;
        px         <= '0;
        py         <= '0;
        pz         <= '0;
        tx_idle    = 38;
        rx_idle    = 73;
        mismatches = 0;
        hold_req   = 0;
        hold_seen  = 0;
        hold_left  = 0;
        stall_cnt  = 0;
        for (int i = 0; i < 3; i++)
        begin
            sh_init[i] = 0;
            sh_ctr[i]  = 0;
        end
        sh_radius = 64'h1_0000;
        sh_weight = 64'h1_0000;
        fill_probes();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows on the reset register values
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(probes[i].op, probes[i].x, probes[i].y, probes[i].z,
                      probes[i].known, probes[i].res);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // registers only change once the block is idle
            item_valid <= 1'b0;
            wait_drained();
            if (ph < 3)
            begin
                tx_idle = 38;
                rx_idle = 73;
            end
            else if (ph < 6)
            begin
                tx_idle = 73;
                rx_idle = 38;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            load_phase_regs(ph);
            // long receiver hold-off while items keep coming: input backs up
            if (ph == 6)
                hold_req++;
            count = (ph == 1) ? 60 : 200;
            for (int k = 0; k < count; k++)
            begin
                // sender pause until the block has handed back everything
                if (ph == 4 && k == 100)
                begin
                    item_valid <= 1'b0;
                    while (pending_q.size() != 0)
                        @(posedge clk);
                end
                random_item();
            end
        end

        item_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
